// File: rtl/core/frqm_pkg.sv
// ============================================================================
// frqm_pkg: shared types and codes for the request queue with merge
// Transaction structs for the command and result ports, outcome and mode
// codes, and the status bundle from the adjacency compare unit.
// ============================================================================
`default_nettype none

package frqm_pkg;

    // Fixed port field widths
    localparam int PORT_SECTOR_W = 48;
    localparam int PORT_COUNT_W  = 16;
    localparam int TAG_W         = 8;
    localparam int OUTCOME_W     = 3;
    localparam int QLEN_W        = 5;
    localparam int TOTAL_W       = 32;

    // Command modes
    localparam logic MODE_ADD      = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    // Result outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_QUEUED     = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MERGED     = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_DISPATCHED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_EMPTY      = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_DROPPED    = 3'd4;

    typedef struct packed {
        logic                     mode;
        logic                     req_type;
        logic [PORT_SECTOR_W-1:0] start_sector;
        logic [PORT_COUNT_W-1:0]  sector_count;
        logic [TAG_W-1:0]         req_tag;
    } t_req;

    typedef struct packed {
        logic [OUTCOME_W-1:0]     outcome;
        logic                     out_type;
        logic [PORT_SECTOR_W-1:0] out_sector;
        logic [PORT_COUNT_W-1:0]  out_count;
        logic [TAG_W-1:0]         out_tag;
        logic [QLEN_W-1:0]        queue_length;
        logic [TOTAL_W-1:0]       added_total;
        logic [TOTAL_W-1:0]       dispatched_total;
        logic [TOTAL_W-1:0]       merged_total;
    } t_rsp;

    // Adjacency compare status
    typedef struct packed {
        logic hit;      // same direction and adjacent on either side
        logic follows;  // new range starts where the entry ends
        logic ovf;      // grown count does not fit
    } t_match;

endpackage

`default_nettype wire

// File: rtl/core/frqm_ram.sv
// ============================================================================
// frqm_ram: request entry storage
// Simple dual-port memory, one write and one read port, registered read data.
// ============================================================================
`default_nettype none

module frqm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 73
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/frqm_match.sv
// ============================================================================
// frqm_match: adjacency compare unit
// Checks a stored entry against the new request: same direction, follows or
// precedes with exact (non-wrapping) sums, and count overflow of the merge.
// ============================================================================
`default_nettype none

module frqm_match #(
    parameter int SECTOR_BITS = 48,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                   i_ent_type,
    input  wire logic [SECTOR_BITS-1:0] i_ent_sector,
    input  wire logic [COUNT_BITS-1:0]  i_ent_count,
    input  wire logic                   i_type,
    input  wire logic [SECTOR_BITS-1:0] i_sector,
    input  wire logic [COUNT_BITS-1:0]  i_count,
    output frqm_pkg::t_match            o_match,
    output logic      [COUNT_BITS-1:0]  o_sum
);

    localparam int SUM_W = ((SECTOR_BITS > COUNT_BITS) ? SECTOR_BITS : COUNT_BITS) + 1;

    logic [SUM_W-1:0]      ent_end;
    logic [SUM_W-1:0]      new_end;
    logic [COUNT_BITS:0]   cnt_sum;
    logic                  follows;
    logic                  precedes;

    assign ent_end  = SUM_W'(i_ent_sector) + SUM_W'(i_ent_count);
    assign new_end  = SUM_W'(i_sector) + SUM_W'(i_count);
    assign follows  = (ent_end == SUM_W'(i_sector));
    assign precedes = (new_end == SUM_W'(i_ent_sector));
    assign cnt_sum  = (COUNT_BITS+1)'(i_ent_count) + (COUNT_BITS+1)'(i_count);

    assign o_match.hit     = (i_ent_type == i_type) && (follows || precedes);
    assign o_match.follows = follows;
    assign o_match.ovf     = cnt_sum[COUNT_BITS];
    assign o_sum           = cnt_sum[COUNT_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/core/fifo_request_queue_with_merge.sv
// ============================================================================
// fifo_request_queue_with_merge: FIFO block I/O request queue with merge
// Ring buffer of requests in one memory. An add walks the queue head to tail
// looking for an adjacent request of the same direction to extend; otherwise
// it appends. A dispatch pops the head. One result transaction per command.
// ============================================================================
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------
//  command   | in        | start && !busy       | i_req (frqm_pkg::t_req)
//  result    | out       | o_done, no backpress | o_rsp (frqm_pkg::t_rsp)
//  config    | in        | i_cfg_we             | i_cfg_data (merge enable)
//
//  Timing: o_done is registered from the state that finishes the command.
//    dispatch on a non-empty queue: head read in S_IDLE, then pop in S_DISP.
//    add with merging off, empty queue, or dispatch on empty: ends in S_IDLE.
//    add with merging on: S_SCAN examines k entries (1..QUEUE_DEPTH),
//    one entry per cycle through the single memory read port.
//  Reset clears pointers, counters and control; entry storage is not cleared
//  (only written entries are ever read). The result side cannot stall.
// ============================================================================
`default_nettype none

module fifo_request_queue_with_merge #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SECTOR_BITS = 48,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // command transaction
    input  wire logic           start,
    output logic                busy,
    input  wire frqm_pkg::t_req i_req,
    // result transaction
    output logic                o_done,
    output frqm_pkg::t_rsp      o_rsp,
    // merge enable register
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_data
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W   = frqm_pkg::TAG_W;
    localparam int ENTRY_W = 1 + SECTOR_BITS + COUNT_BITS + TAG_W;
    localparam int TOT_W   = frqm_pkg::TOTAL_W;
    localparam int PSEC_W  = frqm_pkg::PORT_SECTOR_W;
    localparam int PCNT_W  = frqm_pkg::PORT_COUNT_W;
    localparam int QLEN_W  = frqm_pkg::QLEN_W;

    // Entry layout: {type, sector, count, tag}
    localparam int CNT_LO = TAG_W;
    localparam int SEC_LO = TAG_W + COUNT_BITS;

    // One-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DISP = 3'b100
    } t_state;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_head, n_head;
    logic [IDX_W-1:0]       r_tail, n_tail;
    logic [CNT_W-1:0]       r_total, n_total;
    logic [IDX_W-1:0]       r_idx, n_idx;     // entry under test
    logic [CNT_W-1:0]       r_left, n_left;   // entries still to test, incl. current
    logic [TOT_W-1:0]       r_added, n_added;
    logic [TOT_W-1:0]       r_dispatched, n_dispatched;
    logic [TOT_W-1:0]       r_merged, n_merged;
    logic                   r_merge_en;
    logic                   r_done, n_done;
    frqm_pkg::t_rsp         r_rsp, n_rsp;

    // Latched request payload
    logic                   r_type, n_type;
    logic [SECTOR_BITS-1:0] r_sector, n_sector;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [TAG_W-1:0]       r_tag, n_tag;

    // Memory ports
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [IDX_W-1:0]       rd_addr;
    logic [ENTRY_W-1:0]     rd_data;

    // Entry fields from read data
    logic                   ent_type;
    logic [SECTOR_BITS-1:0] ent_sector;
    logic [COUNT_BITS-1:0]  ent_count;
    logic [TAG_W-1:0]       ent_tag;

    // Request as seen this cycle: port payload at accept, latched after
    logic                   cur_type;
    logic [SECTOR_BITS-1:0] cur_sector;
    logic [COUNT_BITS-1:0]  cur_count;
    logic [TAG_W-1:0]       cur_tag;

    frqm_pkg::t_match       match;
    logic [COUNT_BITS-1:0]  merge_sum;

    logic                   accept;
    logic                   finish_add;
    logic                   rsp_valid;
    logic [frqm_pkg::OUTCOME_W-1:0] rsp_code;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign ent_type   = rd_data[ENTRY_W-1];
    assign ent_sector = rd_data[SEC_LO +: SECTOR_BITS];
    assign ent_count  = rd_data[CNT_LO +: COUNT_BITS];
    assign ent_tag    = rd_data[0 +: TAG_W];

    assign cur_type   = (r_state == S_IDLE) ? i_req.req_type : r_type;
    assign cur_sector = (r_state == S_IDLE) ? SECTOR_BITS'(i_req.start_sector) : r_sector;
    assign cur_count  = (r_state == S_IDLE) ? COUNT_BITS'(i_req.sector_count) : r_count;
    assign cur_tag    = (r_state == S_IDLE) ? i_req.req_tag : r_tag;

    frqm_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    frqm_match #(
        .SECTOR_BITS (SECTOR_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_match (
        .i_ent_type   (ent_type),
        .i_ent_sector (ent_sector),
        .i_ent_count  (ent_count),
        .i_type       (r_type),
        .i_sector     (r_sector),
        .i_count      (r_count),
        .o_match      (match),
        .o_sum        (merge_sum)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_total      = r_total;
        n_idx        = r_idx;
        n_left       = r_left;
        n_added      = r_added;
        n_dispatched = r_dispatched;
        n_merged     = r_merged;
        n_type       = r_type;
        n_sector     = r_sector;
        n_count      = r_count;
        n_tag        = r_tag;
        wr_en        = 1'b0;
        wr_addr      = r_tail;
        wr_data      = {cur_type, cur_sector, cur_count, cur_tag};
        rd_addr      = r_head;
        finish_add   = 1'b0;
        rsp_valid    = 1'b0;
        rsp_code     = frqm_pkg::OUT_QUEUED;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_type   = cur_type;
                    n_sector = cur_sector;
                    n_count  = cur_count;
                    n_tag    = cur_tag;
                    if (i_req.mode == frqm_pkg::MODE_DISPATCH) begin
                        if (r_total == '0) begin
                            rsp_valid = 1'b1;
                            rsp_code  = frqm_pkg::OUT_EMPTY;
                        end else begin
                            // head read is in flight
                            n_state = S_DISP;
                        end
                    end else if (r_merge_en && (r_total != '0)) begin
                        n_state = S_SCAN;
                        n_idx   = r_head;
                        n_left  = r_total;
                    end else begin
                        finish_add = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // prefetch the next slot while testing the current one
                rd_addr = next_slot(r_idx);
                if (match.hit && !match.ovf) begin
                    wr_en     = 1'b1;
                    wr_addr   = r_idx;
                    wr_data   = {ent_type, (match.follows ? ent_sector : r_sector),
                                 merge_sum, ent_tag};
                    n_merged  = r_merged + TOT_W'(1);
                    rsp_valid = 1'b1;
                    rsp_code  = frqm_pkg::OUT_MERGED;
                    n_state   = S_IDLE;
                end else if (match.hit || (r_left == CNT_W'(1))) begin
                    // blocked by overflow, or walk done: append instead
                    finish_add = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_idx  = next_slot(r_idx);
                    n_left = r_left - CNT_W'(1);
                end
            end
            S_DISP: begin
                n_head       = next_slot(r_head);
                n_total      = r_total - CNT_W'(1);
                n_dispatched = r_dispatched + TOT_W'(1);
                rsp_valid    = 1'b1;
                rsp_code     = frqm_pkg::OUT_DISPATCHED;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish_add) begin
            rsp_valid = 1'b1;
            if (r_total == CNT_W'(QUEUE_DEPTH)) begin
                rsp_code = frqm_pkg::OUT_DROPPED;
            end else begin
                wr_en    = 1'b1;
                wr_addr  = r_tail;
                n_tail   = next_slot(r_tail);
                n_total  = r_total + CNT_W'(1);
                n_added  = r_added + TOT_W'(1);
                rsp_code = frqm_pkg::OUT_QUEUED;
            end
        end

        n_done = rsp_valid;
        n_rsp  = r_rsp;
        if (rsp_valid) begin
            n_rsp.outcome          = rsp_code;
            n_rsp.out_type         = 1'b0;
            n_rsp.out_sector       = '0;
            n_rsp.out_count        = '0;
            n_rsp.out_tag          = '0;
            if (rsp_code == frqm_pkg::OUT_DISPATCHED) begin
                n_rsp.out_type   = ent_type;
                n_rsp.out_sector = PSEC_W'(ent_sector);
                n_rsp.out_count  = PCNT_W'(ent_count);
                n_rsp.out_tag    = ent_tag;
            end
            n_rsp.queue_length     = QLEN_W'(n_total);
            n_rsp.added_total      = n_added;
            n_rsp.dispatched_total = n_dispatched;
            n_rsp.merged_total     = n_merged;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_total      <= '0;
            r_idx        <= '0;
            r_left       <= '0;
            r_added      <= '0;
            r_dispatched <= '0;
            r_merged     <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_total      <= n_total;
            r_idx        <= n_idx;
            r_left       <= n_left;
            r_added      <= n_added;
            r_dispatched <= n_dispatched;
            r_merged     <= n_merged;
            r_done       <= n_done;
        end
    end

    // Merge enable register, resets to enabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_merge_en <= i_cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_sector <= n_sector;
        r_count  <= n_count;
        r_tag    <= n_tag;
        r_rsp    <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire
